// ----- sv/dtl_pkg.sv -----
// shared types, constants and the arctangent table of the direction to texel lookup
package dtl_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 2048;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 40;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = ANGLE_BITS + 1;
  localparam int CW           = 36;
  localparam int AW           = 44;

  typedef logic signed [CW-1:0] cvec_t;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t PI_Q40 = 44'sh3243F6A8886;
  localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_t;

  typedef struct packed {
    logic [11:0] texel_column;
    logic [10:0] texel_row;
    logic [22:0] texel_index;
    logic        zero_direction;
  } out_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } reg_idx_e;

  typedef ang_t atan_tab_t [CORDIC_STEPS];

  function automatic logic [63:0] udiv_small(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic ang_t atan_q40(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] t;
    int e;
    sum = '0;
    if (i == 0) begin
      sum = (PI_Q60 + (64'sd1 <<< 21)) >>> 22;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          t = signed'(udiv_small(64'd1 << e, 64'(2 * k + 1)));
          if (k % 2 == 1) sum = sum - t;
          else sum = sum + t;
        end
      end
      sum = (sum + (64'sd1 <<< 21)) >>> 22;
    end
    return AW'(sum);
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t tab;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      tab[i] = atan_q40(i);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

// ----- sv/direction_to_latlong_texel.sv -----
// top level of the direction to lat-long texel lookup
// Accepts one direction per clock and returns its texel, one transaction per cycle sustained
// while the output does not stall. The chain runs: normalize, squared length, 32 square root
// cells, two scaling stages, 40 cordic cells run side by side for azimuth and polar angle,
// one angle magnitude stage, 17 division cells for each angle, then three stages for column,
// row and linear index.
// A stall on the output freezes the whole chain; no new transaction enters until it clears.
module direction_to_latlong_texel (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dtl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dtl_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [12:0]   cfg_data_i
);

  localparam int AB    = dtl_pkg::ANGLE_BITS;
  localparam int QW    = dtl_pkg::DIV_STEPS;
  localparam int FW    = AB + 3;
  localparam int NSQ   = dtl_pkg::SQRT_STEPS;
  localparam int NCO   = dtl_pkg::CORDIC_STEPS;
  localparam int NDV   = dtl_pkg::DIV_STEPS;
  localparam int LAT   = NSQ + 2 + NCO + 1 + NDV;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } side_t;

  logic        en;
  logic        acc;
  logic [12:0] cfg_w_q;
  logic [11:0] cfg_h_q;
  logic [12:0] w;
  logic [11:0] h;

  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 13'd1024;
      cfg_h_q <= 12'd512;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dtl_pkg::REG_IMAGE_WIDTH) cfg_w_q <= cfg_data_i;
      if (cfg_idx_i == dtl_pkg::REG_IMAGE_HEIGHT) cfg_h_q <= cfg_data_i[11:0];
    end
  end

  always_comb begin
    if (cfg_w_q == '0) w = 13'd1;
    else if (cfg_w_q > 13'(dtl_pkg::MAX_WIDTH)) w = 13'(dtl_pkg::MAX_WIDTH);
    else w = cfg_w_q;
    if (cfg_h_q == '0) h = 12'd1;
    else if (cfg_h_q > 12'(dtl_pkg::MAX_HEIGHT)) h = 12'(dtl_pkg::MAX_HEIGHT);
    else h = cfg_h_q;
  end

  // normalize
  logic [16:0] ax, ay, az, m;
  logic [3:0]  sh;
  logic        s1_valid_q, s1_zero_q;
  side_t       s1_q;

  always_comb begin
    ax = in_data_i.dir_x[15] ? unsigned'(17'(-18'(in_data_i.dir_x))) : 17'(in_data_i.dir_x);
    ay = in_data_i.dir_y[15] ? unsigned'(17'(-18'(in_data_i.dir_y))) : 17'(in_data_i.dir_y);
    az = in_data_i.dir_z[15] ? unsigned'(17'(-18'(in_data_i.dir_z))) : 17'(in_data_i.dir_z);
    m  = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    sh = '0;
    if (m < 17'd16384) begin
      for (int b = 0; b < 14; b++) begin
        if (m[b]) sh = 4'(14 - b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.x    <= in_data_i.dir_x <<< sh;
      s1_q.y    <= in_data_i.dir_y <<< sh;
      s1_q.z    <= in_data_i.dir_z <<< sh;
      s1_zero_q <= (m == '0);
    end
  end

  // squared horizontal length
  logic signed [31:0] px, pz;
  logic        s2_valid_q, s2_zero_q;
  logic [31:0] s2_s_q;
  side_t       s2_q;

  assign px = s1_q.x * s1_q.x;
  assign pz = s1_q.z * s1_q.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_s_q    <= unsigned'(px) + unsigned'(pz);
      s2_q      <= s1_q;
      s2_zero_q <= s1_zero_q;
    end
  end

  // valid, zero and side lines
  logic  ln_v_q [1:LAT];
  logic  ln_z_q [1:LAT];
  side_t ln_s_q [1:NSQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= LAT; k++) ln_v_q[k] <= 1'b0;
    end else if (en) begin
      ln_v_q[1] <= s2_valid_q;
      for (int k = 2; k <= LAT; k++) ln_v_q[k] <= ln_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ln_z_q[1] <= s2_zero_q;
      ln_s_q[1] <= s2_q;
      for (int k = 2; k <= LAT; k++) ln_z_q[k] <= ln_z_q[k-1];
      for (int k = 2; k <= NSQ; k++) ln_s_q[k] <= ln_s_q[k-1];
    end
  end

  // square root chain
  logic [31:0] sq_s    [0:NSQ];
  logic [33:0] sq_rem  [0:NSQ];
  logic [31:0] sq_root [0:NSQ];

  assign sq_s[0]    = s2_s_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    dtl_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .step_i (5'(j)),
      .s_i    (sq_s[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .s_o    (sq_s[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  // cordic lanes: 0 azimuth, 1 polar angle
  dtl_pkg::cvec_t pr_y [2];
  dtl_pkg::cvec_t pr_x [2];
  dtl_pkg::cvec_t co_x [2][0:NCO];
  dtl_pkg::cvec_t co_y [2][0:NCO];
  dtl_pkg::ang_t  co_z [2][0:NCO];

  assign pr_y[0] = dtl_pkg::CW'(ln_s_q[NSQ].z);
  assign pr_x[0] = dtl_pkg::CW'(ln_s_q[NSQ].x);
  assign pr_y[1] = signed'({4'b0000, sq_root[NSQ]});
  assign pr_x[1] = signed'({{4{ln_s_q[NSQ].y[15]}}, ln_s_q[NSQ].y, 16'h0000});

  // angle magnitude and sign
  logic                   ab_neg_q [2];
  logic [dtl_pkg::AW-1:0] ab_mag_q [2];
  logic                   dv_neg   [2][0:NDV];
  logic [dtl_pkg::AW-1:0] dv_rem   [2][0:NDV];
  logic [QW-1:0]          dv_q     [2][0:NDV];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    dtl_prep u_prep (
      .clk_i (clk_i),
      .en_i  (en),
      .y_i   (pr_y[l]),
      .x_i   (pr_x[l]),
      .x_o   (co_x[l][0]),
      .y_o   (co_y[l][0]),
      .z_o   (co_z[l][0])
    );

    for (genvar j = 0; j < NCO; j++) begin : g_cordic
      dtl_cordic_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .step_i (6'(j)),
        .x_i    (co_x[l][j]),
        .y_i    (co_y[l][j]),
        .z_i    (co_z[l][j]),
        .x_o    (co_x[l][j+1]),
        .y_o    (co_y[l][j+1]),
        .z_o    (co_z[l][j+1])
      );
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ab_neg_q[l] <= co_z[l][NCO][dtl_pkg::AW-1];
        ab_mag_q[l] <= co_z[l][NCO][dtl_pkg::AW-1] ? unsigned'(-co_z[l][NCO])
                                                    : unsigned'(co_z[l][NCO]);
      end
    end

    assign dv_neg[l][0] = ab_neg_q[l];
    assign dv_rem[l][0] = ab_mag_q[l];
    assign dv_q[l][0]   = '0;

    for (genvar j = 0; j < NDV; j++) begin : g_div
      dtl_div_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (en),
        .first_i (j == 0),
        .neg_i   (dv_neg[l][j]),
        .rem_i   (dv_rem[l][j]),
        .q_i     (dv_q[l][j]),
        .neg_o   (dv_neg[l][j+1]),
        .rem_o   (dv_rem[l][j+1]),
        .q_o     (dv_q[l][j+1])
      );
    end
  end

  // fractions of pi, clamp and scale
  logic signed [FW-1:0] frac [2];
  logic signed [FW-1:0] one;
  logic signed [FW-1:0] phi, th;
  logic [AB+1:0]        phi_ofs;
  logic [AB+14:0]       p_col;
  logic [AB+12:0]       p_row;
  logic                 f1_valid_q, f1_zero_q;
  logic [12:0]          f1_col_q;
  logic [11:0]          f1_row_q;

  always_comb begin
    one = FW'(1) <<< AB;
    for (int l = 0; l < 2; l++) begin
      if (dv_neg[l][NDV]) begin
        frac[l] = -(signed'(FW'(dv_q[l][NDV])) + FW'(dv_rem[l][NDV] != '0));
      end else begin
        frac[l] = signed'(FW'(dv_q[l][NDV]));
      end
    end
    phi = frac[0];
    if (phi < -one) phi = -one;
    if (phi > one) phi = one;
    th = frac[1];
    if (th < 0) th = '0;
    if (th > one) th = one;
    phi_ofs = (AB+2)'(phi + one);
    p_col   = (AB+15)'(phi_ofs) * (AB+15)'(w);
    p_row   = (AB+13)'(th[AB:0]) * (AB+13)'(h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q <= ln_v_q[LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_col_q  <= 13'(p_col >> (AB + 1));
      f1_row_q  <= 12'(p_row >> AB);
      f1_zero_q <= ln_z_q[LAT];
    end
  end

  // wrap column, clamp row
  logic        f2_valid_q, f2_zero_q;
  logic [11:0] f2_col_q;
  logic [10:0] f2_row_q;
  logic [12:0] col_w;
  logic [11:0] row_c;

  always_comb begin
    col_w = (f1_col_q >= w) ? f1_col_q - w : f1_col_q;
    row_c = (f1_row_q >= h) ? h - 12'd1 : f1_row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_valid_q <= 1'b0;
    end else if (en) begin
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_col_q  <= col_w[11:0];
      f2_row_q  <= row_c[10:0];
      f2_zero_q <= f1_zero_q;
    end
  end

  // linear index and output register
  logic          out_valid_q;
  dtl_pkg::out_t out_q, out_d;
  logic [23:0]   idx;

  always_comb begin
    idx = 24'(f2_col_q) + 24'(f2_row_q) * 24'(w);
    if (f2_zero_q) begin
      out_d                = '0;
      out_d.zero_direction = 1'b1;
    end else begin
      out_d.texel_column   = f2_col_q;
      out_d.texel_row      = f2_row_q;
      out_d.texel_index    = idx[22:0];
      out_d.zero_direction = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/dtl_sqrt_cell.sv -----
// one digit cell of the pipelined integer square root
module dtl_sqrt_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [4:0]  step_i,
  input  logic [31:0] s_i,
  input  logic [33:0] rem_i,
  input  logic [31:0] root_i,
  output logic [31:0] s_o,
  output logic [33:0] rem_o,
  output logic [31:0] root_o
);

  logic [4:0]  hi;
  logic [1:0]  pair;
  logic [35:0] cur;
  logic [35:0] trial;
  logic [31:0] s_q;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;

  always_comb begin
    hi    = 5'(5'd31 - {step_i[3:0], 1'b0});
    pair  = step_i[4] ? 2'b00 : s_i[hi -: 2];
    cur   = {rem_i, pair};
    trial = {2'b00, root_i, 2'b01};
    if (cur >= trial) begin
      rem_d  = 34'(cur - trial);
      root_d = {root_i[30:0], 1'b1};
    end else begin
      rem_d  = cur[33:0];
      root_d = {root_i[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_i;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign s_o    = s_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ----- sv/dtl_prep.sv -----
// operand scaling and half-plane fold ahead of a cordic chain, two stages
module dtl_prep (
  input  logic          clk_i,
  input  logic          en_i,
  input  dtl_pkg::cvec_t y_i,
  input  dtl_pkg::cvec_t x_i,
  output dtl_pkg::cvec_t x_o,
  output dtl_pkg::cvec_t y_o,
  output dtl_pkg::ang_t  z_o
);

  logic [dtl_pkg::CW-1:0] ax, ay, m;
  logic [4:0]             sh;
  logic                   spec;
  dtl_pkg::ang_t          spec_ang;
  dtl_pkg::cvec_t         x_q, y_q;
  logic [4:0]             sh_q;
  logic                   spec_q;
  dtl_pkg::ang_t          spec_ang_q;
  dtl_pkg::cvec_t         xs, ys;
  dtl_pkg::cvec_t         xo_q, yo_q, xo_d, yo_d;
  dtl_pkg::ang_t          zo_q, zo_d;

  always_comb begin
    ax = x_i[dtl_pkg::CW-1] ? unsigned'(-x_i) : unsigned'(x_i);
    ay = y_i[dtl_pkg::CW-1] ? unsigned'(-y_i) : unsigned'(y_i);
    m  = (ax > ay) ? ax : ay;
    sh = '0;
    if (m < (dtl_pkg::CW'(1) << 30)) begin
      for (int b = 0; b < 30; b++) begin
        if (m[b]) sh = 5'(30 - b);
      end
    end
    spec     = 1'b0;
    spec_ang = '0;
    if (y_i == '0) begin
      spec     = 1'b1;
      spec_ang = x_i[dtl_pkg::CW-1] ? dtl_pkg::PI_Q40 : '0;
    end else if (x_i == '0) begin
      spec     = 1'b1;
      spec_ang = y_i[dtl_pkg::CW-1] ? -(dtl_pkg::PI_Q40 >>> 1) : (dtl_pkg::PI_Q40 >>> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q        <= x_i;
      y_q        <= y_i;
      sh_q       <= sh;
      spec_q     <= spec;
      spec_ang_q <= spec_ang;
    end
  end

  always_comb begin
    xs = x_q <<< sh_q;
    ys = y_q <<< sh_q;
    if (spec_q) begin
      xo_d = xs;
      yo_d = '0;
      zo_d = spec_ang_q;
    end else if (xs[dtl_pkg::CW-1]) begin
      xo_d = -xs;
      yo_d = -ys;
      zo_d = ys[dtl_pkg::CW-1] ? -dtl_pkg::PI_Q40 : dtl_pkg::PI_Q40;
    end else begin
      xo_d = xs;
      yo_d = ys;
      zo_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xo_q <= xo_d;
      yo_q <= yo_d;
      zo_q <= zo_d;
    end
  end

  assign x_o = xo_q;
  assign y_o = yo_q;
  assign z_o = zo_q;

endmodule

// ----- sv/dtl_cordic_cell.sv -----
// one micro-rotation cell of a vectoring cordic chain
module dtl_cordic_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [5:0]     step_i,
  input  dtl_pkg::cvec_t x_i,
  input  dtl_pkg::cvec_t y_i,
  input  dtl_pkg::ang_t  z_i,
  output dtl_pkg::cvec_t x_o,
  output dtl_pkg::cvec_t y_o,
  output dtl_pkg::ang_t  z_o
);

  dtl_pkg::cvec_t xs, ys, x_d, y_d, x_q, y_q;
  dtl_pkg::ang_t  z_d, z_q;

  always_comb begin
    xs = x_i >>> step_i;
    ys = y_i >>> step_i;
    if (y_i == '0) begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (!y_i[dtl_pkg::CW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + dtl_pkg::ATAN_TAB[step_i];
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - dtl_pkg::ATAN_TAB[step_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- sv/dtl_div_cell.sv -----
// one quotient bit cell of the division of an angle by pi
module dtl_div_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          first_i,
  input  logic                          neg_i,
  input  logic [dtl_pkg::AW-1:0]        rem_i,
  input  logic [dtl_pkg::DIV_STEPS-1:0] q_i,
  output logic                          neg_o,
  output logic [dtl_pkg::AW-1:0]        rem_o,
  output logic [dtl_pkg::DIV_STEPS-1:0] q_o
);

  logic [dtl_pkg::AW-1:0]        t, rem_d, rem_q;
  logic                          ge;
  logic [dtl_pkg::DIV_STEPS-1:0] q_q;
  logic                          neg_q;

  always_comb begin
    t     = first_i ? rem_i : {rem_i[dtl_pkg::AW-2:0], 1'b0};
    ge    = t >= unsigned'(dtl_pkg::PI_Q40);
    rem_d = ge ? t - unsigned'(dtl_pkg::PI_Q40) : t;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      q_q   <= {q_i[dtl_pkg::DIV_STEPS-2:0], ge};
      neg_q <= neg_i;
    end
  end

  assign rem_o = rem_q;
  assign q_o   = q_q;
  assign neg_o = neg_q;

endmodule
